// File: design/gbwc_pkg.sv
// ============================================================================
// gbwc_pkg
// Types, letter masks and rule tables for the G-code block word checker.
// ============================================================================
`default_nettype none

package gbwc_pkg;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_TERMS   = 5;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // verdict codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_UNCHK = 2'd2;

  // G numbers with a rule
  localparam logic [6:0] G00 = 7'd0;
  localparam logic [6:0] G01 = 7'd1;
  localparam logic [6:0] G02 = 7'd2;
  localparam logic [6:0] G03 = 7'd3;
  localparam logic [6:0] G04 = 7'd4;
  localparam logic [6:0] G28 = 7'd28;
  localparam logic [6:0] G50 = 7'd50;
  localparam logic [6:0] G70 = 7'd70;
  localparam logic [6:0] G71 = 7'd71;
  localparam logic [6:0] G72 = 7'd72;
  localparam logic [6:0] G74 = 7'd74;
  localparam logic [6:0] G75 = 7'd75;
  localparam logic [6:0] G76 = 7'd76;
  localparam logic [6:0] G96 = 7'd96;
  localparam logic [6:0] G97 = 7'd97;
  localparam logic [6:0] G99 = 7'd99;

  typedef logic [NUM_LETTERS-1:0] lmask_t;
  typedef logic [NUM_TERMS-1:0][NUM_LETTERS-1:0] terms_t;

  localparam lmask_t LB_F = lmask_t'(1) << 5;
  localparam lmask_t LB_G = lmask_t'(1) << 6;
  localparam lmask_t LB_M = lmask_t'(1) << 12;
  localparam lmask_t LB_N = lmask_t'(1) << 13;
  localparam lmask_t LB_P = lmask_t'(1) << 15;
  localparam lmask_t LB_Q = lmask_t'(1) << 16;
  localparam lmask_t LB_R = lmask_t'(1) << 17;
  localparam lmask_t LB_S = lmask_t'(1) << 18;
  localparam lmask_t LB_T = lmask_t'(1) << 19;
  localparam lmask_t LB_U = lmask_t'(1) << 20;
  localparam lmask_t LB_W = lmask_t'(1) << 22;
  localparam lmask_t LB_X = lmask_t'(1) << 23;
  localparam lmask_t LB_Z = lmask_t'(1) << 25;
  localparam lmask_t LB_NONE = '0;

  typedef enum logic [4:0] {
    R_G00, R_G01, R_G02, R_G04, R_G28, R_G50, R_G70,
    R_G71A, R_G71B, R_G72A, R_G72B, R_G74A, R_G74B,
    R_G75A, R_G75B, R_G76A, R_G76B, R_G96,
    R_ONE_WORD, R_UNCHECKED
  } rule_t;

  // classified word as it travels from front to back
  typedef struct packed {
    lmask_t letter_oh;
    logic   bad;
    logic   last;
    rule_t  rule;
  } word_t;

  function automatic rule_t rule_lookup(input logic [6:0] g, input logic part);
    rule_t r;
    r = R_UNCHECKED;
    case (g)
      G00:      r = R_G00;
      G01:      r = R_G01;
      G02, G03: r = R_G02;
      G04:      r = R_G04;
      G28:      r = R_G28;
      G50:      r = R_G50;
      G70:      r = R_G70;
      G71:      r = part ? R_G71B : R_G71A;
      G72:      r = part ? R_G72B : R_G72A;
      G74:      r = part ? R_G74B : R_G74A;
      G75:      r = part ? R_G75B : R_G75A;
      G76:      r = part ? R_G76B : R_G76A;
      G96, G97: r = R_G96;
      G99:      r = R_ONE_WORD;
      default:  r = R_UNCHECKED;
    endcase
    return r;
  endfunction

  function automatic lmask_t rule_allowed(input rule_t r);
    lmask_t m;
    m = LB_NONE;
    case (r)
      R_G00:   m = LB_N | LB_X | LB_Z | LB_T;
      R_G01:   m = LB_N | LB_X | LB_Z | LB_F;
      R_G02:   m = LB_N | LB_X | LB_Z | LB_R;
      R_G04:   m = LB_N | LB_P;
      R_G28:   m = LB_N | LB_X | LB_Z | LB_R | LB_U | LB_W | LB_M | LB_T;
      R_G50:   m = LB_N | LB_S;
      R_G70:   m = LB_N | LB_P | LB_Q | LB_F | LB_S | LB_T;
      R_G71A:  m = LB_N | LB_U | LB_R;
      R_G71B:  m = LB_N | LB_P | LB_Q | LB_U | LB_W | LB_F | LB_S | LB_T;
      R_G72A:  m = LB_N | LB_W | LB_R;
      R_G72B:  m = LB_N | LB_P | LB_Q | LB_U | LB_W | LB_F | LB_S | LB_T;
      R_G74A:  m = LB_N | LB_R;
      R_G74B:  m = LB_N | LB_Z | LB_Q | LB_F;
      R_G75A:  m = LB_R;
      R_G75B:  m = LB_N | LB_X | LB_P | LB_F;
      R_G76A:  m = LB_R | LB_Q | LB_P;
      R_G76B:  m = LB_X | LB_U | LB_Z | LB_W | LB_R | LB_Q | LB_P | LB_F;
      R_G96:   m = LB_T | LB_S | LB_M;
      default: m = LB_NONE;
    endcase
    return m | LB_G;
  endfunction

  // required-letter terms: the block passes if any nonzero term is fully present
  function automatic terms_t rule_terms(input rule_t r);
    terms_t t;
    t = '0;
    case (r)
      R_G00:   t = {LB_NONE, LB_NONE, LB_NONE, LB_Z, LB_X};
      R_G01:   t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_F};
      R_G02:   t = {LB_NONE, LB_NONE, LB_NONE, LB_X | LB_Z, LB_R};
      R_G04:   t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_P};
      R_G28:   t = {LB_NONE, LB_NONE, LB_NONE, LB_W, LB_U};
      R_G50:   t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_S};
      R_G70:   t = {LB_T, LB_S, LB_F, LB_Q, LB_P};
      R_G71A:  t = {LB_NONE, LB_NONE, LB_NONE, LB_R, LB_U};
      R_G71B:  t = {LB_NONE, LB_W, LB_U, LB_Q, LB_P};
      R_G72A:  t = {LB_NONE, LB_NONE, LB_NONE, LB_R, LB_W};
      R_G72B:  t = {LB_F, LB_W, LB_U, LB_Q, LB_P};
      R_G74A:  t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_R};
      R_G74B:  t = {LB_NONE, LB_NONE, LB_F, LB_Q, LB_Z};
      R_G75A:  t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_R};
      R_G75B:  t = {LB_NONE, LB_NONE, LB_F, LB_P, LB_X};
      R_G76A:  t = {LB_NONE, LB_NONE, LB_P, LB_Q, LB_R};
      R_G76B:  t = {LB_F, LB_R, LB_P, LB_Z | LB_W, LB_X | LB_U};
      R_G96:   t = {LB_NONE, LB_NONE, LB_NONE, LB_NONE, LB_S};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/gbwc_front.sv
// ============================================================================
// gbwc_front
// Classifies an incoming word: letter one-hot, non-letter flag, rule select.
// ============================================================================
`default_nettype none

module gbwc_front (
  input  wire logic [6:0]    g_number,
  input  wire logic          block_part,
  input  wire logic [7:0]    letter,
  input  wire logic          last_word,
  output gbwc_pkg::word_t    word
);
  import gbwc_pkg::*;

  logic   is_letter;
  lmask_t oh;

  always_comb begin
    is_letter = (letter >= CHAR_A) && (letter <= CHAR_Z);
    oh        = '0;
    if (is_letter) begin
      oh = lmask_t'(1) << (5'(letter - CHAR_A));
    end
    word.letter_oh = oh;
    word.bad       = !is_letter;
    word.last      = last_word;
    word.rule      = rule_lookup(g_number, block_part);
  end

endmodule

`default_nettype wire

// File: design/gbwc_queue.sv
// ============================================================================
// gbwc_queue
// Small FIFO of classified items between the front and back parts.
// ============================================================================
`default_nettype none

module gbwc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire gbwc_pkg::word_t push_word,
  input  wire logic            pop,
  output gbwc_pkg::word_t      head_word,
  output logic                 full,
  output logic                 empty
);
  import gbwc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  word_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// File: design/gbwc_back.sv
// ============================================================================
// gbwc_back
// Per-block letter flags, verdict on the last word, registered result.
// ============================================================================
`default_nettype none

module gbwc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire gbwc_pkg::word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status
);
  import gbwc_pkg::*;

  lmask_t     seen_r, seen_nxt;
  logic       bad_r, bad_nxt;
  logic       extra_r, extra_nxt;
  logic       out_valid_r;
  logic [1:0] status_r;
  logic [1:0] verdict;
  lmask_t     allowed;
  terms_t     terms;
  logic       term_hit;

  // a last word can only leave once the result register has room
  assign q_pop = q_valid && (!q_word.last || !out_valid_r || out_ready);

  always_comb begin
    extra_nxt = extra_r || (seen_r != '0) || bad_r;
    seen_nxt  = seen_r | q_word.letter_oh;
    bad_nxt   = bad_r || q_word.bad;
    allowed   = rule_allowed(q_word.rule);
    terms     = rule_terms(q_word.rule);
    term_hit  = 1'b0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      if ((terms[i] != '0) && ((seen_nxt & terms[i]) == terms[i])) begin
        term_hit = 1'b1;
      end
    end
    case (q_word.rule)
      R_UNCHECKED: verdict = ST_UNCHK;
      R_ONE_WORD:  verdict = extra_nxt ? ST_ERR : ST_OK;
      default: begin
        if (bad_nxt || ((seen_nxt & ~allowed) != '0) || !term_hit) begin
          verdict = ST_ERR;
        end else begin
          verdict = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      bad_r       <= 1'b0;
      extra_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_word.last) begin
          seen_r  <= '0;
          bad_r   <= 1'b0;
          extra_r <= 1'b0;
        end else begin
          seen_r  <= seen_nxt;
          bad_r   <= bad_nxt;
          extra_r <= extra_nxt;
        end
      end
      if (q_pop && q_word.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_word.last) begin
      status_r <= verdict;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

// File: design/gcode_block_word_checker.sv
// ============================================================================
// gcode_block_word_checker
// Checks the address letters of one lathe G-code block against its G rule.
// ============================================================================
// Words of a block come in one item at a time (first character of the word,
// the block's G number, part select for the two-block cycles G71, G72 and
// G74..G76, last-word flag). Non-last words produce no result; the last word
// produces one status item: 0 ok, 1 error, 2 G number not checked. Throughput
// is one word per clock while the queue has room: the front classifies each
// word as it is taken and pushes it into a QUEUE_DEPTH-entry queue; the back
// pops one word per cycle unless a last word waits for room in the output
// register, folds it into the seen-letter flags and, on the last word, loads
// the verdict into that register. While a status waits on out_ready, a
// further last word waits in the queue and non-last words keep draining, so
// the input stalls only once the queue fills. Only the G number and part of
// the last word pick the rule; letters of all words of the block count.
`default_nettype none

module gcode_block_word_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // word input
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [6:0] in_g_number,
  input  wire logic       in_block_part,
  input  wire logic [7:0] in_letter,
  input  wire logic       in_last_word,
  // status output
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status
);
  import gbwc_pkg::*;

  word_t in_word;
  word_t head_word;
  logic  q_full, q_empty, q_pop;

  // classification of the incoming item
  gbwc_front u_front (
    .g_number   (in_g_number),
    .block_part (in_block_part),
    .letter     (in_letter),
    .last_word  (in_last_word),
    .word       (in_word)
  );

  assign in_ready = !q_full;

  // decouples the input handshake from the verdict/output side
  gbwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (in_word),
    .pop       (q_pop),
    .head_word (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  // flag update, verdict and result register
  gbwc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_word     (head_word),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status)
  );

`ifndef NO_ASSERTIONS
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && head_word.last |=> out_valid)
    else $error("last word popped without a status item");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_ERR ||
                   out_status == ST_UNCHK))
    else $error("status item carries an undefined code");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && head_word.last && out_valid |-> out_ready)
    else $error("status overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// File: dv/gcode_block_word_checker_tb.sv
// ============================================================================
// gcode_block_word_checker_tb
// Self-checking bench: G-code words in, one verdict per block out.
// ============================================================================
// A fixed list of opening words walks every G rule, both part selects, the
// unsupported numbers and the letter-byte extremes. Random blocks follow, most
// of them built from each rule's legal letters so that ok verdicts are common.
// A scoreboard-style predictor tracks the seen-letter, bad-letter and
// multi-word flags and queues one expected verdict per last word. Both
// handshakes are sampled on the falling edge and driven on the rising edge.
`default_nettype none

module gcode_block_word_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbwc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1525;
  localparam int unsigned HOLD_CYCLES  = 220;     // long output hold-off
  localparam int unsigned HOLD_EVERY   = 500;     // words between hold-offs
  localparam int unsigned DRAIN_CYCLES = 8;       // settle time after the last verdict, plenty
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [6:0] G73  = 7'd73;            // cycle number with no rule
  localparam logic [6:0] G127 = 7'd127;           // top of the number field

  // last-word flag and where the expected verdict of a row comes from
  localparam logic MORE    = 1'b0;
  localparam logic LAST    = 1'b1;
  localparam logic PREDICT = 1'b0;
  localparam logic TYPED   = 1'b1;

  typedef lmask_t [NUM_TERMS-1:0] need_set_t;
  typedef enum logic [1:0] {RK_TABLE, RK_ONE_WORD, RK_NONE} rule_kind_e;
  typedef struct packed {
    rule_kind_e kind;
    lmask_t     allow;     // legal letters, G included
    need_set_t  need;      // block passes if any nonzero term is fully present
  } word_rule_t;

  typedef struct packed {
    logic [6:0] g;
    logic       part;
    logic [7:0] ch;
    logic       last;
    logic       how;
    logic [1:0] status;    // only meaningful for TYPED rows
  } word_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [6:0] in_g_number;
  logic       in_block_part;
  logic [7:0] in_letter;
  logic       in_last_word;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;

  gcode_block_word_checker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_g_number   (in_g_number),
    .in_block_part (in_block_part),
    .in_letter     (in_letter),
    .in_last_word  (in_last_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor of the block's flags and verdict
  // --------------------------------------------------------------------------
  lmask_t      block_letters;     // letters seen in the current block
  logic        block_bad;         // a non A..Z byte in the current block
  logic        block_multi;       // more than one word in the current block
  logic [1:0]  verdicts_due[$];   // verdicts not yet returned, oldest first
  int unsigned verdict_tally[3];

  function automatic lmask_t mask_of(input string s);
    lmask_t m;
    m = '0;
    for (int i = 0; i < s.len(); i++) m |= lmask_t'(1) << (s[i] - CHAR_A);
    return m;
  endfunction

  // every letter of any is a requirement on its own
  function automatic word_rule_t rule_of_letters(input string allow, input string any);
    word_rule_t r;
    r.kind  = RK_TABLE;
    r.allow = mask_of(allow) | mask_of("G");
    r.need  = '0;
    for (int i = 0; i < any.len(); i++) r.need[i] = lmask_t'(1) << (any[i] - CHAR_A);
    return r;
  endfunction

  function automatic word_rule_t rule_for(input logic [6:0] g, input logic part);
    word_rule_t r;
    r.kind  = RK_NONE;
    r.allow = '1;
    r.need  = '0;
    case (g)
      G00:      r = rule_of_letters("NXZT", "XZ");
      G01:      r = rule_of_letters("NXZF", "F");
      G02, G03: begin
        r = rule_of_letters("NXZR", "R");
        r.need[1] = mask_of("XZ");
      end
      G04:      r = rule_of_letters("NP", "P");
      G28:      r = rule_of_letters("NXZRUWMT", "UW");
      G50:      r = rule_of_letters("NS", "S");
      G70:      r = rule_of_letters("NPQFST", "PQFST");
      G71:      r = part ? rule_of_letters("NPQUWFST", "PQUW") : rule_of_letters("NUR", "UR");
      G72:      r = part ? rule_of_letters("NPQUWFST", "PQUWF") : rule_of_letters("NWR", "WR");
      G74:      r = part ? rule_of_letters("NZQF", "ZQF") : rule_of_letters("NR", "R");
      G75:      r = part ? rule_of_letters("NXPF", "XPF") : rule_of_letters("R", "R");
      G76: begin
        if (part) begin
          // thread cycle second block: X with U, or Z with W, or P, R, F alone
          r = rule_of_letters("XUZWRQPF", "PRF");
          r.need[3] = mask_of("XU");
          r.need[4] = mask_of("ZW");
        end else begin
          r = rule_of_letters("RQP", "RQP");
        end
      end
      G96, G97: r = rule_of_letters("TSM", "S");
      G99:      r.kind = RK_ONE_WORD;
      default:  r.kind = RK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] judge(input word_rule_t r, input lmask_t seen,
                                       input logic bad, input logic multi);
    logic hit;
    hit = 1'b0;
    if (r.kind == RK_NONE) return ST_UNCHK;
    if (r.kind == RK_ONE_WORD) return multi ? ST_ERR : ST_OK;   // letter does not matter
    if (bad) return ST_ERR;
    if ((seen & ~r.allow) != '0) return ST_ERR;
    for (int i = 0; i < NUM_TERMS; i++)
      if (r.need[i] != '0 && (seen & r.need[i]) == r.need[i]) hit = 1'b1;
    return hit ? ST_OK : ST_ERR;
  endfunction

  // fold one accepted word; a last word closes the block and queues its verdict
  task automatic fold_word(input logic [6:0] g, input logic part, input logic [7:0] ch,
                           input logic last, input logic how, input logic [1:0] typed);
    logic [1:0] st;
    if (block_letters != '0 || block_bad) block_multi = 1'b1;
    if (ch >= CHAR_A && ch <= CHAR_Z) block_letters |= lmask_t'(1) << (ch - CHAR_A);
    else block_bad = 1'b1;
    if (last) begin
      // only the last word's number and part pick the rule
      st = judge(rule_for(g, part), block_letters, block_bad, block_multi);
      if (how == TYPED) st = typed;
      verdicts_due.push_back(st);
      verdict_tally[st]++;
      block_letters = '0;
      block_bad     = 1'b0;
      block_multi   = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Opening words: every rule, both parts, unsupported numbers, byte extremes
  // --------------------------------------------------------------------------
  word_row_t opening_rows [25] = '{
    '{G00,  1'b1, "X",   LAST, PREDICT, ST_OK},    // part ignored off the cycles
    '{G01,  1'b0, "F",   LAST, PREDICT, ST_OK},
    '{G02,  1'b0, "X",   MORE, PREDICT, ST_OK},    // number changes inside block
    '{G03,  1'b0, "Z",   LAST, PREDICT, ST_OK},
    '{G04,  1'b0, "P",   LAST, PREDICT, ST_OK},
    '{G28,  1'b0, "W",   LAST, PREDICT, ST_OK},
    '{G50,  1'b0, "S",   LAST, PREDICT, ST_OK},
    '{G70,  1'b0, "T",   LAST, PREDICT, ST_OK},
    '{G71,  1'b0, "U",   LAST, PREDICT, ST_OK},
    '{G71,  1'b1, "W",   LAST, PREDICT, ST_OK},
    '{G72,  1'b0, "R",   LAST, PREDICT, ST_OK},
    '{G72,  1'b1, "F",   LAST, PREDICT, ST_OK},
    '{G74,  1'b0, "R",   LAST, PREDICT, ST_OK},
    '{G74,  1'b1, "Q",   LAST, PREDICT, ST_OK},
    '{G75,  1'b0, "R",   LAST, PREDICT, ST_OK},
    '{G75,  1'b1, "X",   LAST, PREDICT, ST_OK},
    '{G76,  1'b0, "P",   LAST, PREDICT, ST_OK},
    '{G76,  1'b1, "P",   LAST, PREDICT, ST_OK},
    '{G97,  1'b0, "S",   LAST, PREDICT, ST_OK},
    '{G99,  1'b0, 8'hFF, LAST, TYPED,   ST_OK},    // one word passes, any byte
    '{G99,  1'b0, "X",   MORE, PREDICT, ST_OK},
    '{G99,  1'b1, "Z",   LAST, TYPED,   ST_ERR},   // two words fail
    '{G73,  1'b0, "R",   LAST, TYPED,   ST_UNCHK},
    '{G127, 1'b1, 8'h00, LAST, TYPED,   ST_UNCHK},
    '{G00,  1'b0, "x",   LAST, TYPED,   ST_ERR}    // lowercase is a bad letter
  };

  logic [6:0] g_pool [16] = '{G00, G01, G02, G03, G04, G28, G50, G70,
                              G71, G72, G74, G75, G76, G96, G97, G99};

  // --------------------------------------------------------------------------
  // Word sender: bursts of items with random gaps
  // --------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned blocks_sent;
  int unsigned in_stall_cycles;

  // called at a rising edge; returns at the rising edge that took the item
  task automatic offer_word(input logic [6:0] g, input logic part, input logic [7:0] ch,
                            input logic last, input logic how, input logic [1:0] typed);
    int unsigned gap;
    logic        took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid      <= 1'b0;
        in_g_number   <= 7'($urandom);
        in_block_part <= 1'($urandom);
        in_letter     <= 8'($urandom);
        in_last_word  <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_g_number   <= g;
    in_block_part <= part;
    in_letter     <= ch;
    in_last_word  <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    words_sent++;
    if (last) blocks_sent++;
    fold_word(g, part, ch, last, how, typed);
  endtask

  // One random block. Most are built from the legal letters of one rule; the
  // rest are raw bytes on any number, or blocks whose number changes.
  task automatic random_block();
    int unsigned flavor;
    int unsigned n_words;
    int unsigned roll;
    int unsigned idx;
    logic [6:0]  g_final;
    logic [6:0]  g_word;
    logic        part;
    logic        part_word;
    logic [7:0]  ch;
    word_rule_t  r;
    flavor  = $urandom_range(0, 99);
    n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    g_final = (flavor < 80) ? g_pool[$urandom_range(0, 15)] : 7'($urandom_range(0, 127));
    part    = 1'($urandom);
    r       = rule_for(g_final, part);
    for (int i = 0; i < n_words; i++) begin
      g_word    = g_final;
      part_word = part;
      if (flavor >= 90 && i != n_words - 1) begin
        g_word    = 7'($urandom_range(0, 127));
        part_word = 1'($urandom);
      end
      roll = $urandom_range(0, 19);
      if (flavor < 80 && roll < 17) begin
        do idx = $urandom_range(0, NUM_LETTERS - 1); while (!r.allow[idx]);
        ch = CHAR_A + 8'(idx);
      end else if (flavor >= 90 || roll < 19) begin
        ch = CHAR_A + 8'($urandom_range(0, NUM_LETTERS - 1));
      end else begin
        ch = 8'($urandom);
      end
      if (flavor >= 80 && flavor < 90) ch = 8'($urandom);
      offer_word(g_word, part_word, ch, i == n_words - 1, PREDICT, ST_OK);
    end
  endtask

  always @(negedge clk)
    if (rst_n && in_valid && !in_ready) in_stall_cycles++;

  // --------------------------------------------------------------------------
  // Verdict receiver: its own stall modes plus occasional long hold-offs
  // --------------------------------------------------------------------------
  logic        hold_req;
  int unsigned holds_done;
  int unsigned faults;
  int unsigned verdicts_seen;

  initial begin : verdict_sink
    logic [1:0]  want;
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    int unsigned hold_left;
    logic        toggle;
    out_ready = 1'b0;
    rx_mode   = RX_OPEN;
    rx_left   = 0;
    hold_left = 0;
    toggle    = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("%0t: verdict %0d with none expected", $realtime, out_status);
        end else begin
          want = verdicts_due.pop_front();
          if (out_status !== want) begin
            faults++;
            if (faults <= 10)
              $display("%0t: verdict #%0d expected %0d, got %0d",
                       $realtime, verdicts_seen, want, out_status);
          end
        end
      end
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
        holds_done++;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(30, 200);
      end
      rx_left--;
      toggle = ~toggle;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom);
          RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
          default:   out_ready <= toggle;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned next_hold_at;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_g_number   = '0;
    in_block_part = 1'b0;
    in_letter     = '0;
    in_last_word  = 1'b0;
    hold_req      = 1'b0;
    block_letters = '0;
    block_bad     = 1'b0;
    block_multi   = 1'b0;
    next_hold_at  = 300;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      offer_word(opening_rows[i].g, opening_rows[i].part, opening_rows[i].ch,
                 opening_rows[i].last, opening_rows[i].how, opening_rows[i].status);

    while (words_sent < $size(opening_rows) + RANDOM_WORDS) begin
      // output held off while words keep coming: queue fills, input stalls
      if (words_sent >= next_hold_at) begin
        hold_req     = 1'b1;
        next_hold_at += HOLD_EVERY;
      end
      random_block();
    end
    in_valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    faults += verdicts_due.size();

    $display("covered %0d words in %0d blocks: %0d ok, %0d error, %0d unchecked verdicts",
             words_sent, blocks_sent, verdict_tally[ST_OK], verdict_tally[ST_ERR],
             verdict_tally[ST_UNCHK]);
    $display("input held back %0d cycles, %0d long output hold-offs, %0d faults",
             in_stall_cycles, holds_done, faults);
    if (faults == 0) $display("gcode_block_word_checker_tb: PASS");
    else $display("gcode_block_word_checker_tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdicts_due.size());
    $display("gcode_block_word_checker_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
